[hw/rtl/json_string_unescaper_defines.svh]
// Assertion macros used by the unescaper RTL.
// No dependencies; include with the bare file name.
`ifndef JSON_STRING_UNESCAPER_DEFINES_SVH
`define JSON_STRING_UNESCAPER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define JSU_ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define JSU_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/jsu_pkg.sv]
// Types, codes and decode helpers for the JSON string unescaper.
// No dependencies; imported by json_string_unescaper.
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_NOQUOTE = 3'd2,
    ST_CUTESC  = 3'd3,
    ST_SHORTU  = 3'd4,
    ST_BADHEX  = 3'd5,
    ST_UNKESC  = 3'd6,
    ST_UNTERM  = 3'd7
  } status_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] LIM_ONE = 16'h0080;
  localparam logic [15:0] LIM_TWO = 16'h0800;
  localparam logic [7:0]  LEAD2   = 8'hC0;
  localparam logic [7:0]  LEAD3   = 8'hE0;
  localparam logic [7:0]  CONT    = 8'h80;

  // {valid, value} of an ASCII hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // {valid, byte} of a single-character escape
  function automatic logic [8:0] esc_decode(input logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      8'h22, 8'h5C, 8'h2F: r = {1'b1, b};
      8'h62:               r = {1'b1, 8'h08};
      8'h66:               r = {1'b1, 8'h0C};
      8'h6E:               r = {1'b1, 8'h0A};
      8'h72:               r = {1'b1, 8'h0D};
      8'h74:               r = {1'b1, 8'h09};
      default:             r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/json_string_unescaper.sv]
// JSON string unescaper: raw quoted-string bytes in, decoded UTF-8 bytes out.
// Depends on jsu_pkg and json_string_unescaper_defines.svh.
//
// Usage:
//   Input beats carry one raw byte each on s_tdata, starting at the opening
//   quote; s_tlast marks the final byte of the buffer. Output beats carry a
//   decoded byte on m_tdata and a status code on m_tuser (0 data byte,
//   1 done, 2 no quote, 3 cut escape, 4 short \u, 5 bad hex, 6 unknown
//   escape, 7 unterminated). m_tlast marks the last beat caused by one
//   input byte. An input byte gives 0 to 4 output beats.
// Timing:
//   Each accepted byte is decoded in the cycle it arrives and its beats land
//   in a 4-entry result buffer; the first beat is visible in the next cycle.
//   One beat drains per cycle while m_tready is high, so plain bytes sustain
//   one byte per cycle and a byte giving more than one beat keeps s_tready
//   low until only its last beat is left; the drain of the result buffer sets this rate.
// Reset and stalls:
//   rst empties the result buffer and returns to waiting for an opening
//   quote. While the receiver stalls the buffer holds; a new byte is taken
//   only when the buffer is empty or empties in that same cycle.
`include "json_string_unescaper_defines.svh"

module json_string_unescaper (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] data_byte
  input  logic             s_tlast,   // is_last
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output jsu_pkg::status_t m_tuser,   // [2:0] status
  output logic             m_tlast    // last_of_run
);
  import jsu_pkg::*;

  // decoder state
  mode_t       mode, mode_next;
  logic [1:0]  hex_seen, hex_seen_next;
  logic [15:0] acc, acc_next;

  // result buffer, head at entry 0
  logic [7:0]  ent_byte [4];
  status_t     ent_stat [4];
  logic [2:0]  cnt;

  logic        s_accept, m_pop;
  logic [4:0]  hex_dec;
  logic [8:0]  esc_dec;
  logic [15:0] acc_new;

  // results of the byte at the input
  logic [1:0]  pre_cnt;
  logic [7:0]  pre_byte [3];
  logic        tail_en;
  status_t     tail_stat;
  logic [7:0]  enc_byte [3];
  logic [1:0]  enc_len;

  assign m_pop    = m_tvalid && m_tready;
  assign s_tready = (cnt == 3'd0) || (cnt == 3'd1 && m_tready);
  assign s_accept = s_tvalid && s_tready;

  assign hex_dec = hex_decode(s_tdata);
  assign esc_dec = esc_decode(s_tdata);
  assign acc_new = {acc[11:0], hex_dec[3:0]};

  // UTF-8 encode of the completed code unit
  always_comb begin
    enc_byte[0] = acc_new[7:0];
    enc_byte[1] = 8'd0;
    enc_byte[2] = 8'd0;
    enc_len     = 2'd1;
    if (acc_new < LIM_ONE) begin
      enc_len = 2'd1;
    end else if (acc_new < LIM_TWO) begin
      enc_byte[0] = LEAD2 | {3'b000, acc_new[10:6]};
      enc_byte[1] = CONT | {2'b00, acc_new[5:0]};
      enc_len     = 2'd2;
    end else begin
      enc_byte[0] = LEAD3 | {4'b0000, acc_new[15:12]};
      enc_byte[1] = CONT | {2'b00, acc_new[11:6]};
      enc_byte[2] = CONT | {2'b00, acc_new[5:0]};
      enc_len     = 2'd3;
    end
  end

  // next state of the decoder
  always_comb begin
    mode_next     = mode;
    hex_seen_next = hex_seen;
    acc_next      = acc;
    unique case (mode)
      MODE_IDLE: begin
        if (s_tdata == CH_QUOTE && !s_tlast) mode_next = MODE_STR;
      end
      MODE_STR: begin
        if (s_tdata == CH_QUOTE) begin
          mode_next = MODE_IDLE;
        end else if (s_tdata == CH_BSLASH) begin
          mode_next = s_tlast ? MODE_IDLE : MODE_ESC;
        end else begin
          mode_next = s_tlast ? MODE_IDLE : MODE_STR;
        end
      end
      MODE_ESC: begin
        if (esc_dec[8]) begin
          mode_next = s_tlast ? MODE_IDLE : MODE_STR;
        end else if (s_tdata == CH_U) begin
          hex_seen_next = 2'd0;
          acc_next      = 16'd0;
          mode_next     = s_tlast ? MODE_IDLE : MODE_HEX;
        end else begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_HEX: begin
        if (!hex_dec[4]) begin
          mode_next = MODE_IDLE;
        end else begin
          acc_next = acc_new;
          if (hex_seen == 2'd3) begin
            hex_seen_next = 2'd0;
            mode_next     = s_tlast ? MODE_IDLE : MODE_STR;
          end else begin
            hex_seen_next = hex_seen + 2'd1;
            mode_next     = s_tlast ? MODE_IDLE : MODE_HEX;
          end
        end
      end
      default: mode_next = MODE_IDLE;
    endcase
  end

  // result beats: decoded bytes first, then an optional status beat
  always_comb begin
    pre_cnt     = 2'd0;
    pre_byte[0] = 8'd0;
    pre_byte[1] = 8'd0;
    pre_byte[2] = 8'd0;
    tail_en     = 1'b0;
    tail_stat   = ST_BYTE;
    unique case (mode)
      MODE_IDLE: begin
        if (s_tdata != CH_QUOTE) begin
          tail_en   = 1'b1;
          tail_stat = ST_NOQUOTE;
        end else if (s_tlast) begin
          tail_en   = 1'b1;
          tail_stat = ST_UNTERM;
        end
      end
      MODE_STR: begin
        if (s_tdata == CH_QUOTE) begin
          tail_en   = 1'b1;
          tail_stat = ST_DONE;
        end else if (s_tdata == CH_BSLASH) begin
          tail_en   = s_tlast;
          tail_stat = ST_CUTESC;
        end else begin
          pre_cnt     = 2'd1;
          pre_byte[0] = s_tdata;
          tail_en     = s_tlast;
          tail_stat   = ST_UNTERM;
        end
      end
      MODE_ESC: begin
        if (esc_dec[8]) begin
          pre_cnt     = 2'd1;
          pre_byte[0] = esc_dec[7:0];
          tail_en     = s_tlast;
          tail_stat   = ST_UNTERM;
        end else if (s_tdata == CH_U) begin
          tail_en   = s_tlast;
          tail_stat = ST_SHORTU;
        end else begin
          tail_en   = 1'b1;
          tail_stat = ST_UNKESC;
        end
      end
      MODE_HEX: begin
        if (!hex_dec[4]) begin
          tail_en   = 1'b1;
          tail_stat = ST_BADHEX;
        end else if (hex_seen == 2'd3) begin
          pre_cnt     = enc_len;
          pre_byte[0] = enc_byte[0];
          pre_byte[1] = enc_byte[1];
          pre_byte[2] = enc_byte[2];
          tail_en     = s_tlast;
          tail_stat   = ST_UNTERM;
        end else begin
          tail_en   = s_tlast;
          tail_stat = ST_SHORTU;
        end
      end
      default: ;
    endcase
  end

  // advance decoder state on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      hex_seen <= 2'd0;
      acc      <= 16'd0;
    end else if (s_accept) begin
      mode     <= mode_next;
      hex_seen <= hex_seen_next;
      acc      <= acc_next;
    end
  end

  // buffer fill count: load on accept, else drain one per pop
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (s_accept) begin
      cnt <= {1'b0, pre_cnt} + {2'b00, tail_en};
    end else if (m_pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  // buffer payload: load all entries, or shift toward the head
  always_ff @(posedge clk) begin
    if (s_accept) begin
      ent_byte[0] <= (pre_cnt > 2'd0) ? pre_byte[0] : 8'd0;
      ent_stat[0] <= (pre_cnt > 2'd0) ? ST_BYTE : tail_stat;
      ent_byte[1] <= (pre_cnt > 2'd1) ? pre_byte[1] : 8'd0;
      ent_stat[1] <= (pre_cnt > 2'd1) ? ST_BYTE : tail_stat;
      ent_byte[2] <= (pre_cnt > 2'd2) ? pre_byte[2] : 8'd0;
      ent_stat[2] <= (pre_cnt > 2'd2) ? ST_BYTE : tail_stat;
      ent_byte[3] <= 8'd0;
      ent_stat[3] <= tail_stat;
    end else if (m_pop) begin
      ent_byte[0] <= ent_byte[1];
      ent_stat[0] <= ent_stat[1];
      ent_byte[1] <= ent_byte[2];
      ent_stat[1] <= ent_stat[2];
      ent_byte[2] <= ent_byte[3];
      ent_stat[2] <= ent_stat[3];
    end
  end

  // drive the output beat from the head entry
  assign m_tvalid = (cnt != 3'd0);
  assign m_tdata  = ent_byte[0];
  assign m_tuser  = ent_stat[0];
  assign m_tlast  = (cnt == 3'd1);

  // checks
  `JSU_ASSERT_SAME(a_status_closes_run, clk, rst, m_tvalid && m_tuser != ST_BYTE,
    m_tlast, "status beat is not the last of its run")
  `JSU_ASSERT_NEXT(a_noquote_reported, clk, rst,
    s_accept && mode == MODE_IDLE && s_tdata != CH_QUOTE,
    m_tvalid && m_tuser == ST_NOQUOTE && m_tlast && mode == MODE_IDLE,
    "stray byte before opening quote not reported")
  `JSU_ASSERT_NEXT(a_uesc_starts_hex, clk, rst,
    s_accept && mode == MODE_ESC && s_tdata == CH_U && !s_tlast,
    mode == MODE_HEX && hex_seen == 2'd0 && acc == 16'd0 && !m_tvalid,
    "\\u escape did not start a clean hex run")
  `JSU_ASSERT_SAME(a_no_accept_in_burst, clk, rst, s_accept,
    cnt <= 3'd1, "input taken while a multi-beat run is pending")

endmodule
